// File: src/sgbl_pkg.sv
// Shared types and codes for the spatial grid bucket list block.
package sgbl_pkg;

  // Request codes.
  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_REMOVE    = 3'd1;
  localparam logic [2:0] REQ_MOVE      = 3'd2;
  localparam logic [2:0] REQ_READ_HEAD = 3'd3;
  localparam logic [2:0] REQ_READ_NEXT = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // Widest index and cell number carried between the sequencer and the store.
  localparam int unsigned ADDR_W = 8;

  // Access requests from the sequencer to the list store.
  typedef struct packed {
    logic              head_rd;
    logic [ADDR_W-1:0] head_raddr;
    logic              head_wr;
    logic [ADDR_W-1:0] head_waddr;
    logic [ADDR_W-1:0] head_wdata;
    logic              obj_rd;
    logic [ADDR_W-1:0] obj_raddr;
    logic              link_wr;
    logic              cell_wr;
    logic [ADDR_W-1:0] obj_waddr;
    logic [ADDR_W-1:0] link_wdata;
    logic [ADDR_W-1:0] cell_wdata;
  } mem_req_t;

  // Registered read data from the list store.
  typedef struct packed {
    logic [ADDR_W-1:0] head_data;
    logic [ADDR_W-1:0] link_data;
    logic [ADDR_W-1:0] cell_data;
  } mem_rsp_t;

endpackage

// File: src/spatial_grid_bucket_lists.sv
// Top level: request sequencer for the spatial grid bucket lists.
//
//  Channel   Handshake           Signals
//  --------  ------------------  ----------------------------------------------
//  request   start && !busy      req_type, item_index, pos_x, pos_y, cell_query
//  result    done (one cycle)    status, cell_now, link_value, relinked
//
// Every request gives one result. Rejected and unused requests answer in the
// cycle after the transfer. A head or link read and a move within its cell
// answer after one memory read; an insert reads the target head and pushes;
// a remove reads the object and its cell head, then walks the list unless the
// object leads it, through the single read port of each memory; a move to
// another cell then pushes as an insert. After reset, busy stays high for a
// clearing pass over the larger of the object count and the cell count; the
// receiver cannot stall, so a result is shown for exactly one cycle.
module spatial_grid_bucket_lists #(
  parameter int GRID_BITS   = 3,
  parameter int MAX_OBJECTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type,
  input  logic [7:0] item_index,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [5:0] cell_query,
  output logic       done,
  output logic [1:0] status,
  output logic [5:0] cell_now,
  output logic [7:0] link_value,
  output logic       relinked
);

  localparam int CELL_W = 2 * GRID_BITS;
  localparam int HOP_W  = $clog2(MAX_OBJECTS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_HEAD_Q    = 3'd1;
  localparam logic [2:0] S_RD_OBJ    = 3'd2;
  localparam logic [2:0] S_RD_HEAD   = 3'd3;
  localparam logic [2:0] S_WALK      = 3'd4;
  localparam logic [2:0] S_WALK_DATA = 3'd5;
  localparam logic [2:0] S_UNLINKED  = 3'd6;
  localparam logic [2:0] S_PUSH_RD   = 3'd7;

  sgbl_pkg::mem_req_t mreq;
  sgbl_pkg::mem_rsp_t mrsp;
  logic               clearing;

  logic [2:0]        state, state_next;
  logic [2:0]        req, req_next;
  logic [7:0]        idx, idx_next;
  logic [CELL_W-1:0] target, target_next;
  logic [CELL_W-1:0] query, query_next;
  logic [CELL_W-1:0] old_cell, old_cell_next;
  logic [7:0]        after, after_next;
  logic [7:0]        cur, cur_next;
  logic [HOP_W-1:0]  hops, hops_next;
  logic              done_next;
  logic [1:0]        status_next;
  logic [CELL_W-1:0] cell_out, cell_out_next;
  logic [7:0]        link_value_next;
  logic              relinked_next;

  logic [CELL_W-1:0] in_target;
  logic [CELL_W-1:0] in_query;
  logic              in_bad_index;
  logic              cur_end;
  logic [7:0]        cell_wide;

  sgbl_store #(
    .GRID_BITS  (GRID_BITS),
    .MAX_OBJECTS(MAX_OBJECTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .mreq    (mreq),
    .mrsp    (mrsp),
    .clearing(clearing)
  );

  // Cell of the incoming position and the wrapped cell query.
  assign in_target    = {pos_y[7 -: GRID_BITS], pos_x[7 -: GRID_BITS]};
  assign in_query     = CELL_W'(cell_query);
  assign in_bad_index = (item_index == 8'd0) || ({1'b0, item_index} >= 9'(MAX_OBJECTS));

  // The walk ends at the end marker, an out-of-range index or the hop limit.
  assign cur_end = (cur == 8'd0) || ({1'b0, cur} >= 9'(MAX_OBJECTS)) ||
                   (hops == HOP_W'(MAX_OBJECTS));

  assign busy      = (state != S_IDLE) || clearing;
  assign cell_wide = 8'(cell_out);
  assign cell_now  = cell_wide[5:0];

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_next      = state;
    req_next        = req;
    idx_next        = idx;
    target_next     = target;
    query_next      = query;
    old_cell_next   = old_cell;
    after_next      = after;
    cur_next        = cur;
    hops_next       = hops;
    done_next       = 1'b0;
    status_next     = status;
    cell_out_next   = cell_out;
    link_value_next = link_value;
    relinked_next   = relinked;
    mreq            = '0;

    case (state)
      S_IDLE: begin
        if (start && !clearing) begin
          req_next    = req_type;
          idx_next    = item_index;
          target_next = in_target;
          query_next  = in_query;
          if (req_type == sgbl_pkg::REQ_READ_HEAD) begin
            mreq.head_rd    = 1'b1;
            mreq.head_raddr = 8'(in_query);
            state_next      = S_HEAD_Q;
          end else if (req_type > sgbl_pkg::REQ_READ_NEXT || in_bad_index) begin
            // Unused codes answer all zero; a bad index is rejected.
            done_next       = 1'b1;
            status_next     = (req_type > sgbl_pkg::REQ_READ_NEXT) ?
                              sgbl_pkg::ST_OK : sgbl_pkg::ST_BAD_INDEX;
            cell_out_next   = '0;
            link_value_next = 8'd0;
            relinked_next   = 1'b0;
          end else if (req_type == sgbl_pkg::REQ_INSERT) begin
            mreq.head_rd    = 1'b1;
            mreq.head_raddr = 8'(in_target);
            state_next      = S_PUSH_RD;
          end else begin
            mreq.obj_rd    = 1'b1;
            mreq.obj_raddr = item_index;
            state_next     = S_RD_OBJ;
          end
        end
      end

      S_HEAD_Q: begin
        done_next       = 1'b1;
        status_next     = sgbl_pkg::ST_OK;
        cell_out_next   = query;
        link_value_next = mrsp.head_data;
        relinked_next   = 1'b0;
        state_next      = S_IDLE;
      end

      S_RD_OBJ: begin
        old_cell_next = mrsp.cell_data[CELL_W-1:0];
        after_next    = mrsp.link_data;
        if (req == sgbl_pkg::REQ_READ_NEXT ||
            (req == sgbl_pkg::REQ_MOVE && mrsp.cell_data[CELL_W-1:0] == target)) begin
          // Plain read, or a move that stays in the same cell.
          done_next       = 1'b1;
          status_next     = sgbl_pkg::ST_OK;
          cell_out_next   = mrsp.cell_data[CELL_W-1:0];
          link_value_next = mrsp.link_data;
          relinked_next   = 1'b0;
          state_next      = S_IDLE;
        end else begin
          mreq.head_rd    = 1'b1;
          mreq.head_raddr = 8'(mrsp.cell_data[CELL_W-1:0]);
          state_next      = S_RD_HEAD;
        end
      end

      S_RD_HEAD: begin
        if (mrsp.head_data == idx) begin
          // The object leads its list: the head skips over it.
          mreq.head_wr    = 1'b1;
          mreq.head_waddr = 8'(old_cell);
          mreq.head_wdata = after;
          state_next      = S_UNLINKED;
        end else begin
          cur_next   = mrsp.head_data;
          hops_next  = '0;
          state_next = S_WALK;
        end
      end

      S_WALK: begin
        if (cur_end) begin
          done_next       = 1'b1;
          status_next     = sgbl_pkg::ST_NOT_FOUND;
          cell_out_next   = old_cell;
          link_value_next = after;
          relinked_next   = 1'b0;
          state_next      = S_IDLE;
        end else begin
          mreq.obj_rd    = 1'b1;
          mreq.obj_raddr = cur;
          hops_next      = hops + HOP_W'(1);
          state_next     = S_WALK_DATA;
        end
      end

      S_WALK_DATA: begin
        if (mrsp.link_data == idx) begin
          // The predecessor now links past the object.
          mreq.link_wr    = 1'b1;
          mreq.obj_waddr  = cur;
          mreq.link_wdata = after;
          state_next      = S_UNLINKED;
        end else begin
          cur_next   = mrsp.link_data;
          state_next = S_WALK;
        end
      end

      S_UNLINKED: begin
        // The unlinked object's link and cell are zeroed.
        mreq.link_wr    = 1'b1;
        mreq.cell_wr    = 1'b1;
        mreq.obj_waddr  = idx;
        mreq.link_wdata = 8'd0;
        mreq.cell_wdata = 8'd0;
        if (req == sgbl_pkg::REQ_MOVE) begin
          mreq.head_rd    = 1'b1;
          mreq.head_raddr = 8'(target);
          state_next      = S_PUSH_RD;
        end else begin
          done_next       = 1'b1;
          status_next     = sgbl_pkg::ST_OK;
          cell_out_next   = '0;
          link_value_next = 8'd0;
          relinked_next   = 1'b0;
          state_next      = S_IDLE;
        end
      end

      S_PUSH_RD: begin
        // Push the object at the head of the target cell.
        mreq.link_wr    = 1'b1;
        mreq.cell_wr    = 1'b1;
        mreq.obj_waddr  = idx;
        mreq.link_wdata = mrsp.head_data;
        mreq.cell_wdata = 8'(target);
        mreq.head_wr    = 1'b1;
        mreq.head_waddr = 8'(target);
        mreq.head_wdata = idx;
        done_next       = 1'b1;
        status_next     = sgbl_pkg::ST_OK;
        cell_out_next   = target;
        link_value_next = mrsp.head_data;
        relinked_next   = (req == sgbl_pkg::REQ_MOVE);
        state_next      = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Request context and result registers.
  always_ff @(posedge clk) begin
    req        <= req_next;
    idx        <= idx_next;
    target     <= target_next;
    query      <= query_next;
    old_cell   <= old_cell_next;
    after      <= after_next;
    cur        <= cur_next;
    hops       <= hops_next;
    status     <= status_next;
    cell_out   <= cell_out_next;
    link_value <= link_value_next;
    relinked   <= relinked_next;
  end

endmodule

// File: src/sgbl_store.sv
// List store: cell head memory and per-object link and cell memories.
module sgbl_store #(
  parameter int GRID_BITS   = 3,
  parameter int MAX_OBJECTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  sgbl_pkg::mem_req_t mreq,
  output sgbl_pkg::mem_rsp_t mrsp,
  output logic               clearing
);

  localparam int CELL_W      = 2 * GRID_BITS;
  localparam int CELL_COUNT  = 1 << CELL_W;
  localparam int IDX_W       = $clog2(MAX_OBJECTS);
  localparam int CLEAR_COUNT = (MAX_OBJECTS > CELL_COUNT) ? MAX_OBJECTS : CELL_COUNT;
  localparam int CLR_W       = $clog2(CLEAR_COUNT);

  logic [sgbl_pkg::ADDR_W-1:0] head_mem [CELL_COUNT];
  logic [sgbl_pkg::ADDR_W-1:0] link_mem [MAX_OBJECTS];
  logic [CELL_W-1:0]           cell_mem [MAX_OBJECTS];

  logic [sgbl_pkg::ADDR_W-1:0] head_q;
  logic [sgbl_pkg::ADDR_W-1:0] link_q;
  logic [CELL_W-1:0]           cell_q;

  logic [CELL_W-1:0] head_ra;
  logic [CELL_W-1:0] head_wa;
  logic [IDX_W-1:0]  obj_ra;
  logic [IDX_W-1:0]  obj_wa;
  logic [CLR_W-1:0]  clr_idx;
  logic              clr_obj;

  assign head_ra = mreq.head_raddr[CELL_W-1:0];
  assign head_wa = mreq.head_waddr[CELL_W-1:0];
  assign obj_ra  = mreq.obj_raddr[IDX_W-1:0];
  assign obj_wa  = mreq.obj_waddr[IDX_W-1:0];
  assign clr_obj = (32'(clr_idx) < 32'(MAX_OBJECTS));

  // Clearing pass after reset: per cycle one head entry is zeroed, and one object entry while the index is in range.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + CLR_W'(1);
      if (clr_idx == CLR_W'(CLEAR_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Cell head memory with a registered read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      head_mem[clr_idx[CELL_W-1:0]] <= '0;
    end else if (mreq.head_wr) begin
      head_mem[head_wa] <= mreq.head_wdata;
    end
    if (mreq.head_rd) begin
      head_q <= head_mem[head_ra];
    end
  end

  // Object link and cell memories, read together at one index.
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_obj) begin
        link_mem[clr_idx[IDX_W-1:0]] <= '0;
        cell_mem[clr_idx[IDX_W-1:0]] <= '0;
      end
    end else begin
      if (mreq.link_wr) begin
        link_mem[obj_wa] <= mreq.link_wdata;
      end
      if (mreq.cell_wr) begin
        cell_mem[obj_wa] <= mreq.cell_wdata[CELL_W-1:0];
      end
    end
    if (mreq.obj_rd) begin
      link_q <= link_mem[obj_ra];
      cell_q <= cell_mem[obj_ra];
    end
  end

  assign mrsp.head_data = head_q;
  assign mrsp.link_data = link_q;
  assign mrsp.cell_data = sgbl_pkg::ADDR_W'(cell_q);

endmodule

// File: tb/sv/spatial_grid_bucket_lists_checker.sv
// Checker for the spatial grid bucket lists: predicts every answer and compares it.
module spatial_grid_bucket_lists_checker #(
  parameter int GRID_BITS   = 3,
  parameter int MAX_OBJECTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] req_type,
  input  logic [7:0] item_index,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [5:0] cell_query,
  input  logic       done,
  input  logic [1:0] status,
  input  logic [5:0] cell_now,
  input  logic [7:0] link_value,
  input  logic       relinked,
  output int         failures,
  output int         pending
);

  localparam int CELL_COUNT  = 1 << (2 * GRID_BITS);
  localparam int COORD_SHIFT = 8 - GRID_BITS;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] cell_no;
    logic [7:0] link;
    logic       moved;
  } grid_answer_t;

  // Shadow copy of the list store.
  logic [7:0] shadow_heads [CELL_COUNT];
  logic [7:0] shadow_links [MAX_OBJECTS];
  logic [5:0] shadow_cells [MAX_OBJECTS];

  grid_answer_t answers_due [$];
  int           fail_tally = 0;

  // Cell number of a coordinate pair: row from the top bits of y, column from x.
  function automatic int grid_cell(input logic [7:0] x, input logic [7:0] y);
    int col;
    int row;
    col = int'(x) >> COORD_SHIFT;
    row = int'(y) >> COORD_SHIFT;
    return ((row << GRID_BITS) | col) & (CELL_COUNT - 1);
  endfunction

  function void push_object(input int home, input int idx);
    shadow_cells[idx] = 6'(home);
    shadow_links[idx] = shadow_heads[home & (CELL_COUNT - 1)];
    shadow_heads[home & (CELL_COUNT - 1)] = 8'(idx);
  endfunction

  // Unlinks an object from the list of its stored cell; returns 0 when absent.
  function bit unlink_object(input int idx);
    int home;
    int after;
    int walk;
    int nxt;
    bit found;
    home  = int'(shadow_cells[idx]) & (CELL_COUNT - 1);
    after = int'(shadow_links[idx]);
    walk  = int'(shadow_heads[home]);
    found = 1'b0;
    if (walk == idx) begin
      shadow_heads[home] = 8'(after);
      found = 1'b1;
    end else begin
      // The walk is bounded so that a looped list cannot hang it.
      for (int hops = 0; hops < MAX_OBJECTS; hops++) begin
        if (walk == 0 || walk >= MAX_OBJECTS) break;
        nxt = int'(shadow_links[walk]);
        if (nxt == idx) begin
          shadow_links[walk] = 8'(after);
          found = 1'b1;
          break;
        end
        walk = nxt;
      end
    end
    if (found) begin
      shadow_links[idx] = '0;
      shadow_cells[idx] = '0;
    end
    return found;
  endfunction

  // Applies one request to the shadow store and returns the answer it gives.
  function grid_answer_t serve_request(input logic [2:0] req, input logic [7:0] idx,
                                       input logic [7:0] x, input logic [7:0] y,
                                       input logic [5:0] query);
    grid_answer_t ans;
    int target;
    ans = '0;
    if (req == sgbl_pkg::REQ_READ_HEAD) begin
      ans.cell_no = 6'(int'(query) & (CELL_COUNT - 1));
      ans.link    = shadow_heads[int'(query) & (CELL_COUNT - 1)];
    end else if (req <= sgbl_pkg::REQ_READ_NEXT) begin
      if (idx == 0 || int'(idx) >= MAX_OBJECTS) begin
        ans.status = sgbl_pkg::ST_BAD_INDEX;
      end else begin
        case (req)
          sgbl_pkg::REQ_INSERT: begin
            push_object(grid_cell(x, y), int'(idx));
            ans.cell_no = shadow_cells[idx];
            ans.link    = shadow_links[idx];
          end
          sgbl_pkg::REQ_REMOVE: begin
            if (!unlink_object(int'(idx))) begin
              ans.status  = sgbl_pkg::ST_NOT_FOUND;
              ans.cell_no = shadow_cells[idx];
              ans.link    = shadow_links[idx];
            end
          end
          sgbl_pkg::REQ_MOVE: begin
            target = grid_cell(x, y);
            if ((int'(shadow_cells[idx]) & (CELL_COUNT - 1)) != target) begin
              if (unlink_object(int'(idx))) begin
                push_object(target, int'(idx));
                ans.moved = 1'b1;
              end else begin
                ans.status = sgbl_pkg::ST_NOT_FOUND;
              end
            end
            ans.cell_no = shadow_cells[idx];
            ans.link    = shadow_links[idx];
          end
          default: begin
            ans.cell_no = shadow_cells[idx];
            ans.link    = shadow_links[idx];
          end
        endcase
      end
    end
    return ans;
  endfunction

  // Results are checked before a new request is taken, since a result that
  // arrives at the same edge belongs to an earlier transfer.
  always @(posedge clk) begin
    grid_answer_t due;
    if (rst) begin
      foreach (shadow_heads[i]) shadow_heads[i] = '0;
      foreach (shadow_links[i]) shadow_links[i] = '0;
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      answers_due.delete();
    end else begin
      if (done) begin
        if (answers_due.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("grid check: unexpected result: status %0d cell %0d link %0d relinked %0d",
                     status, cell_now, link_value, relinked);
        end else begin
          due = answers_due.pop_front();
          if (status !== due.status || cell_now !== due.cell_no ||
              link_value !== due.link || relinked !== due.moved) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("grid check: expected status %0d cell %0d link %0d relinked %0d",
                       due.status, due.cell_no, due.link, due.moved);
              $display("grid check:      got status %0d cell %0d link %0d relinked %0d",
                       status, cell_now, link_value, relinked);
            end
          end
        end
      end
      if (start && !busy)
        answers_due.push_back(serve_request(req_type, item_index, pos_x, pos_y, cell_query));
    end
    failures <= fail_tally;
    pending  <= answers_due.size();
  end

endmodule

// File: tb/sv/spatial_grid_bucket_lists_tb.sv
// Testbench top for the spatial grid bucket lists: stimulus, checker hookup and verdict.
module spatial_grid_bucket_lists_tb;

  // Request codes the block ignores.
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  localparam int RANDOM_REQUESTS = 450;
  localparam int CYCLE_LIMIT     = 1000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] req_type = '0;
  logic [7:0] item_index = '0;
  logic [7:0] pos_x = '0;
  logic [7:0] pos_y = '0;
  logic [5:0] cell_query = '0;
  logic       done;
  logic [1:0] status;
  logic [5:0] cell_now;
  logic [7:0] link_value;
  logic       relinked;
  int         failures;
  int         pending;
  int         cycles = 0;

  // Objects believed to be listed, used to steer removes and moves.
  logic [7:0] listed [$];
  bit         is_listed [256];
  bit         quiet_phase = 1'b0;

  always #5 clk = ~clk;

  spatial_grid_bucket_lists dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .item_index(item_index), .pos_x(pos_x), .pos_y(pos_y),
    .cell_query(cell_query), .done(done), .status(status), .cell_now(cell_now),
    .link_value(link_value), .relinked(relinked)
  );

  spatial_grid_bucket_lists_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .item_index(item_index), .pos_x(pos_x), .pos_y(pos_y),
    .cell_query(cell_query), .done(done), .status(status), .cell_now(cell_now),
    .link_value(link_value), .relinked(relinked),
    .failures(failures), .pending(pending)
  );

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("spatial_grid_bucket_lists verification failed");
      $finish;
    end
  end

  // Presents one request and returns at the edge where it is transferred.
  task automatic send_request(input logic [2:0] req, input logic [7:0] idx,
                              input logic [7:0] x, input logic [7:0] y,
                              input logic [5:0] query);
    start      <= 1'b1;
    req_type   <= req;
    item_index <= idx;
    pos_x      <= x;
    pos_y      <= y;
    cell_query <= query;
    do @(posedge clk); while (busy);
  endtask

  // Idles the request side for a random stretch, mostly short.
  task automatic idle_gap();
    int pick;
    int span;
    pick = $urandom_range(99);
    if (quiet_phase || pick < 50) span = 0;
    else if (pick < 85) span = $urandom_range(3, 1);
    else if (pick < 97) span = $urandom_range(12, 4);
    else span = $urandom_range(60, 20);
    if (span > 0) begin
      start <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] unlisted_index();
    logic [7:0] idx;
    idx = 8'($urandom_range(255, 1));
    for (int tries = 0; tries < 8 && is_listed[idx]; tries++)
      idx = 8'($urandom_range(255, 1));
    return idx;
  endfunction

  task automatic random_request();
    int pick;
    int slot;
    logic [7:0] idx;
    logic [5:0] query;
    pick  = $urandom_range(99);
    query = 6'($urandom_range(63));
    if (listed.size() > 40 && pick < 30) pick = 35;
    if (pick < 30) begin
      // Insert of an object not yet in any list.
      idx = unlisted_index();
      if (!is_listed[idx]) begin
        listed.push_back(idx);
        is_listed[idx] = 1'b1;
      end
      send_request(sgbl_pkg::REQ_INSERT, idx, 8'($urandom), 8'($urandom), query);
    end else if (pick < 50 && listed.size() > 0) begin
      // Remove of a listed object.
      slot = $urandom_range(listed.size() - 1);
      idx  = listed[slot];
      listed.delete(slot);
      is_listed[idx] = 1'b0;
      send_request(sgbl_pkg::REQ_REMOVE, idx, 8'($urandom), 8'($urandom), query);
    end else if (pick < 70 && listed.size() > 0) begin
      // Move of a listed object to a random position.
      idx = listed[$urandom_range(listed.size() - 1)];
      send_request(sgbl_pkg::REQ_MOVE, idx, 8'($urandom), 8'($urandom), query);
    end else if (pick < 80) begin
      send_request(sgbl_pkg::REQ_READ_HEAD, 8'($urandom), 8'($urandom), 8'($urandom),
                   query);
    end else if (pick < 90) begin
      send_request(sgbl_pkg::REQ_READ_NEXT, 8'($urandom_range(255, 1)), 8'($urandom),
                   8'($urandom), query);
    end else if (pick < 93) begin
      send_request(3'($urandom_range(sgbl_pkg::REQ_READ_NEXT)), '0, 8'($urandom),
                   8'($urandom), query);
    end else if (pick < 96) begin
      send_request(3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)), 8'($urandom),
                   8'($urandom), 8'($urandom), query);
    end else if (pick < 99) begin
      // Remove or move of an arbitrary object, often absent from its list.
      send_request(($urandom_range(1) != 0) ? sgbl_pkg::REQ_REMOVE : sgbl_pkg::REQ_MOVE,
                   8'($urandom_range(255, 1)), 8'($urandom), 8'($urandom), query);
    end else if (listed.size() > 0) begin
      // Rare insert of an object already listed.
      idx = listed[$urandom_range(listed.size() - 1)];
      send_request(sgbl_pkg::REQ_INSERT, idx, 8'($urandom), 8'($urandom), query);
    end else begin
      send_request(sgbl_pkg::REQ_READ_HEAD, 8'($urandom), 8'($urandom), 8'($urandom),
                   query);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: field extremes, every request and the corner cases.
    send_request(sgbl_pkg::REQ_INSERT, 8'd255, 8'd255, 8'd255, 6'd0);
    send_request(sgbl_pkg::REQ_INSERT, 8'd1, 8'd0, 8'd0, 6'd63);
    send_request(sgbl_pkg::REQ_INSERT, 8'd2, 8'd31, 8'd31, 6'd0);
    idle_gap();
    send_request(sgbl_pkg::REQ_READ_HEAD, 8'd0, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_READ_NEXT, 8'd2, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_READ_HEAD, 8'd255, 8'd255, 8'd255, 6'd63);
    // A move inside the same cell, then one that has to walk past the head.
    send_request(sgbl_pkg::REQ_MOVE, 8'd2, 8'd10, 8'd20, 6'd0);
    send_request(sgbl_pkg::REQ_MOVE, 8'd1, 8'd255, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_REMOVE, 8'd255, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_REMOVE, 8'd255, 8'd0, 8'd0, 6'd0);
    // Index zero is refused by every request that names an object.
    send_request(sgbl_pkg::REQ_INSERT, 8'd0, 8'd255, 8'd255, 6'd63);
    send_request(sgbl_pkg::REQ_REMOVE, 8'd0, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_MOVE, 8'd0, 8'd128, 8'd128, 6'd0);
    send_request(sgbl_pkg::REQ_READ_NEXT, 8'd0, 8'd0, 8'd0, 6'd0);
    // Unused request codes.
    send_request(REQ_SPARE_FIRST, 8'd255, 8'd255, 8'd255, 6'd63);
    send_request(REQ_SPARE_FIRST + 3'd1, 8'd7, 8'd1, 8'd2, 6'd5);
    send_request(REQ_SPARE_LAST, 8'd128, 8'd64, 8'd32, 6'd42);
    // The same object inserted twice, then removed.
    send_request(sgbl_pkg::REQ_INSERT, 8'd3, 8'd128, 8'd64, 6'd0);
    send_request(sgbl_pkg::REQ_INSERT, 8'd3, 8'd128, 8'd64, 6'd0);
    send_request(sgbl_pkg::REQ_REMOVE, 8'd3, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_READ_HEAD, 8'd0, 8'd0, 8'd0, 6'd20);
    // Move of an object that was never listed.
    send_request(sgbl_pkg::REQ_MOVE, 8'd200, 8'd200, 8'd200, 6'd0);
    send_request(sgbl_pkg::REQ_READ_NEXT, 8'd1, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_REMOVE, 8'd2, 8'd0, 8'd0, 6'd0);
    send_request(sgbl_pkg::REQ_REMOVE, 8'd1, 8'd0, 8'd0, 6'd0);
    idle_gap();

    // Random part: mostly consistent inserts, removes and moves.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(39) == 0) quiet_phase = !quiet_phase;
      random_request();
      idle_gap();
    end

    // Drain: wait for every answer, then let the block settle.
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("spatial_grid_bucket_lists verification clean");
    end else begin
      $display("spatial_grid_bucket_lists verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/sgbl_pkg.sv
src/sgbl_store.sv
src/spatial_grid_bucket_lists.sv
tb/sv/spatial_grid_bucket_lists_checker.sv
tb/sv/spatial_grid_bucket_lists_tb.sv
